/* hw/rtl/store_forward_ring_buffer_core_defines.svh */
// Assertion macros shared by the ring buffer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef STORE_FORWARD_RING_BUFFER_CORE_DEFINES_SVH
`define STORE_FORWARD_RING_BUFFER_CORE_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define SFRB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition must never be true outside reset.
`define SFRB_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

/* hw/rtl/sfrb_pkg.sv */
// Package for the store-and-forward ring buffer: field widths, codes,
// controller types and the snapshot CRC function. No dependencies.
package sfrb_pkg;

	localparam int DEPTH_DEF        = 64;
	localparam int PAYLOAD_BITS_DEF = 32;

	localparam int ACTION_W   = 4;
	localparam int KIND_W     = 8;
	localparam int WORD_W     = 32;
	localparam int SAVED_W    = 16;
	localparam int STATUS_W   = 3;
	localparam int FILL_OUT_W = 7;
	localparam int POS_OUT_W  = 6;
	localparam int CRC_W      = 16;
	localparam int TOTAL_W    = 32;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

	typedef enum logic [ACTION_W-1:0] {
		ACT_STORE      = 4'd0,
		ACT_PEEK       = 4'd1,
		ACT_COMMIT     = 4'd2,
		ACT_DISCARD    = 4'd3,
		ACT_CLEAR      = 4'd4,
		ACT_CONNECT    = 4'd5,
		ACT_DISCONNECT = 4'd6,
		ACT_RESTORE    = 4'd7,
		ACT_REPORT     = 4'd8
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_EMPTY     = 3'd1,
		STAT_IGNORED   = 3'd2,
		STAT_OVERWRITE = 3'd3,
		STAT_REJECTED  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PEEK
	} state_t;

	typedef struct packed {
		logic sweep;
		logic step;
		logic res_load;
		logic peek_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic peek_hit;
		logic out_busy;
	} dp_stat_t;

	// CRC-16/MODBUS over count, head, tail as big-endian 16-bit words.
	function automatic logic [CRC_W-1:0] crc16_snapshot(
		input logic [SAVED_W-1:0] c,
		input logic [SAVED_W-1:0] h,
		input logic [SAVED_W-1:0] t
	);
		logic [47:0]      data;
		logic [CRC_W-1:0] crc;
		data = {c, h, t};
		crc  = CRC_INIT;
		for (int i = 0; i < 6; i++) begin
			crc = crc ^ {8'h00, data[47 - 8*i -: 8]};
			for (int j = 0; j < 8; j++) begin
				crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
			end
		end
		return crc;
	endfunction

endpackage

/* hw/rtl/sfrb_ctrl.sv */
// Controller state machine: entry clear sweep, item acceptance, peek read.
// Depends on sfrb_pkg and the assertion macro header.
`include "store_forward_ring_buffer_core_defines.svh"

module sfrb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 out_stall,
	input  sfrb_pkg::dp_stat_t   stat,
	output sfrb_pkg::ctrl_cmd_t  cmd
);
	import sfrb_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_free;

	assign out_free = !stat.out_busy || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && out_free && stat.peek_hit) state_d = ST_PEEK;
			end
			ST_PEEK: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
			end
			ST_IDLE: begin
				in_stall     = !out_free;
				cmd.step     = in_valid && out_free;
				cmd.res_load = in_valid && out_free && !stat.peek_hit;
			end
			ST_PEEK: begin
				cmd.peek_load = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`SFRB_ASSERT(a_sweep_stall, clk, arst_n, (state_q == ST_CLEAR) |-> in_stall, "item taken during sweep")
	`SFRB_ASSERT(a_peek_free, clk, arst_n, (state_q == ST_PEEK) |-> !stat.out_busy, "peek result blocked")
	`SFRB_ASSERT(a_peek_back, clk, arst_n, (state_q == ST_PEEK) |=> (state_q == ST_IDLE), "peek not closed")

endmodule

/* hw/rtl/sfrb_datapath.sv */
// Datapath: entry memory, pointers, counters, snapshot CRC and result register.
// Depends on sfrb_pkg and the assertion macro header.
`include "store_forward_ring_buffer_core_defines.svh"

module sfrb_datapath #(
	parameter int DEPTH        = sfrb_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = sfrb_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sfrb_pkg::ctrl_cmd_t              cmd,
	output sfrb_pkg::dp_stat_t               stat,
	input  logic                             out_stall,
	input  logic [sfrb_pkg::ACTION_W-1:0]    action,
	input  logic [sfrb_pkg::KIND_W-1:0]      entry_kind,
	input  logic [sfrb_pkg::WORD_W-1:0]      entry_word,
	input  logic [sfrb_pkg::SAVED_W-1:0]     saved_count,
	input  logic [sfrb_pkg::SAVED_W-1:0]     saved_head,
	input  logic [sfrb_pkg::SAVED_W-1:0]     saved_tail,
	input  logic [sfrb_pkg::SAVED_W-1:0]     saved_check,
	output logic                             out_valid,
	output logic [sfrb_pkg::STATUS_W-1:0]    status,
	output logic [sfrb_pkg::KIND_W-1:0]      out_kind,
	output logic [sfrb_pkg::WORD_W-1:0]      out_word,
	output logic [sfrb_pkg::FILL_OUT_W-1:0]  fill_count,
	output logic [sfrb_pkg::POS_OUT_W-1:0]   write_pos,
	output logic [sfrb_pkg::POS_OUT_W-1:0]   read_pos,
	output logic [sfrb_pkg::CRC_W-1:0]       snapshot_check,
	output logic                             link_up,
	output logic [sfrb_pkg::TOTAL_W-1:0]     stores_total,
	output logic [sfrb_pkg::TOTAL_W-1:0]     reads_total
);
	import sfrb_pkg::*;

	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int SW    = (PAYLOAD_BITS < WORD_W) ? PAYLOAD_BITS : WORD_W;
	localparam int EW    = KIND_W + SW;
	localparam logic [SAVED_W-1:0] DEPTH_SAVED = SAVED_W'(DEPTH);

	logic [EW-1:0]      entries_q [DEPTH];
	logic [EW-1:0]      rd_data_q;
	logic [PW-1:0]      clr_idx_q;
	logic [CW-1:0]      fill_q;
	logic [PW-1:0]      head_q;
	logic [PW-1:0]      tail_q;
	logic               link_q;
	logic [TOTAL_W-1:0] stores_q;
	logic [TOTAL_W-1:0] reads_q;

	logic               out_valid_q;
	status_t            status_q;
	logic [KIND_W-1:0]  kind_q;
	logic [WORD_W-1:0]  word_q;

	logic [CW-1:0]      fill_d;
	logic [PW-1:0]      head_d;
	logic [PW-1:0]      tail_d;
	logic               link_d;
	logic [TOTAL_W-1:0] stores_d;
	logic [TOTAL_W-1:0] reads_d;
	status_t            status_d;
	logic               store_we;
	logic               restore_ok;

	logic               mem_we;
	logic [PW-1:0]      mem_addr;
	logic [EW-1:0]      mem_wdata;

	logic [31:0]        fill_ext;
	logic [31:0]        head_ext;
	logic [31:0]        tail_ext;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		r = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
		return r;
	endfunction

	assign stat.sweep_last = (clr_idx_q == PW'(DEPTH - 1));
	assign stat.peek_hit   = (action == ACT_PEEK) && (fill_q != '0);
	assign stat.out_busy   = out_valid_q;

	assign restore_ok = (saved_check == crc16_snapshot(saved_count, saved_head, saved_tail))
		&& (saved_count <= DEPTH_SAVED) && (saved_head < DEPTH_SAVED)
		&& (saved_tail < DEPTH_SAVED);

	always_comb begin
		fill_d   = fill_q;
		head_d   = head_q;
		tail_d   = tail_q;
		link_d   = link_q;
		stores_d = stores_q;
		reads_d  = reads_q;
		status_d = STAT_OK;
		store_we = 1'b0;
		case (action)
			ACT_STORE: begin
				if (link_q) begin
					status_d = STAT_IGNORED;
				end else begin
					store_we = 1'b1;
					if (fill_q == CW'(DEPTH)) begin
						tail_d   = next_ptr(tail_q);
						status_d = STAT_OVERWRITE;
					end else begin
						fill_d = fill_q + CW'(1);
					end
					head_d   = next_ptr(head_q);
					stores_d = stores_q + TOTAL_W'(1);
				end
			end
			ACT_PEEK: begin
				if (fill_q == '0) status_d = STAT_EMPTY;
			end
			ACT_COMMIT, ACT_DISCARD: begin
				if (fill_q == '0) begin
					status_d = STAT_EMPTY;
				end else begin
					tail_d = next_ptr(tail_q);
					fill_d = fill_q - CW'(1);
					if (action == ACT_COMMIT) reads_d = reads_q + TOTAL_W'(1);
				end
			end
			ACT_CLEAR: begin
				fill_d = '0;
				head_d = '0;
				tail_d = '0;
			end
			ACT_CONNECT: begin
				link_d = 1'b1;
			end
			ACT_DISCONNECT: begin
				link_d = 1'b0;
			end
			ACT_RESTORE: begin
				if (restore_ok) begin
					fill_d = saved_count[CW-1:0];
					head_d = saved_head[PW-1:0];
					tail_d = saved_tail[PW-1:0];
				end else begin
					fill_d   = '0;
					head_d   = '0;
					tail_d   = '0;
					status_d = STAT_REJECTED;
				end
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
	end

	assign mem_we    = cmd.sweep || (cmd.step && store_we);
	assign mem_addr  = cmd.sweep ? clr_idx_q : head_q;
	assign mem_wdata = cmd.sweep ? '0 : {entry_kind, entry_word[SW-1:0]};

	always_ff @(posedge clk) begin
		if (mem_we) entries_q[mem_addr] <= mem_wdata;
		rd_data_q <= entries_q[tail_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.sweep) begin
			clr_idx_q <= clr_idx_q + PW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			link_q   <= 1'b0;
			stores_q <= '0;
			reads_q  <= '0;
		end else if (cmd.step) begin
			fill_q   <= fill_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			link_q   <= link_d;
			stores_q <= stores_d;
			reads_q  <= reads_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load || cmd.peek_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= status_d;
			kind_q   <= '0;
			word_q   <= '0;
		end else if (cmd.peek_load) begin
			status_q <= STAT_OK;
			kind_q   <= rd_data_q[EW-1 -: KIND_W];
			word_q   <= WORD_W'(rd_data_q[SW-1:0]);
		end
	end

	// State registers only move together with a result load, so they match it.
	assign fill_ext = 32'(fill_q);
	assign head_ext = 32'(head_q);
	assign tail_ext = 32'(tail_q);

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign out_kind       = kind_q;
	assign out_word       = word_q;
	assign fill_count     = fill_ext[FILL_OUT_W-1:0];
	assign write_pos      = head_ext[POS_OUT_W-1:0];
	assign read_pos       = tail_ext[POS_OUT_W-1:0];
	assign snapshot_check = crc16_snapshot(fill_ext[SAVED_W-1:0], head_ext[SAVED_W-1:0],
		tail_ext[SAVED_W-1:0]);
	assign link_up        = link_q;
	assign stores_total   = stores_q;
	assign reads_total    = reads_q;

	`SFRB_ASSERT(a_fill_bound, clk, arst_n, fill_q <= CW'(DEPTH), "fill above depth")
	`SFRB_ASSERT(a_ptr_bound, clk, arst_n, (head_q <= PW'(DEPTH - 1)) && (tail_q <= PW'(DEPTH - 1)), "pointer out of range")
	`SFRB_ASSERT(a_cmd_excl, clk, arst_n, $onehot0({cmd.sweep, cmd.step, cmd.peek_load}), "overlapping commands")
	`SFRB_ASSERT(a_peek_src, clk, arst_n, cmd.peek_load |-> $past(cmd.step), "peek load without step")

endmodule

/* hw/rtl/store_forward_ring_buffer_core.sv */
// Results are registered: an accepted item loads the result register, while a
// peek of a held entry first passes the registered entry read and the ST_PEEK state.
// Throughput: one item per cycle while in_stall is low; a peek that finds an entry
// holds in_stall high through ST_PEEK. Reset: pointers, counters and link flag clear
// at once; then a sweep zeroes the entry memory while in_stall stays high.
module store_forward_ring_buffer_core #(
	parameter int DEPTH        = sfrb_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = sfrb_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [sfrb_pkg::ACTION_W-1:0]    action,
	input  logic [sfrb_pkg::KIND_W-1:0]      entry_kind,
	input  logic [sfrb_pkg::WORD_W-1:0]      entry_word,
	input  logic [sfrb_pkg::SAVED_W-1:0]     saved_count,
	input  logic [sfrb_pkg::SAVED_W-1:0]     saved_head,
	input  logic [sfrb_pkg::SAVED_W-1:0]     saved_tail,
	input  logic [sfrb_pkg::SAVED_W-1:0]     saved_check,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [sfrb_pkg::STATUS_W-1:0]    status,
	output logic [sfrb_pkg::KIND_W-1:0]      out_kind,
	output logic [sfrb_pkg::WORD_W-1:0]      out_word,
	output logic [sfrb_pkg::FILL_OUT_W-1:0]  fill_count,
	output logic [sfrb_pkg::POS_OUT_W-1:0]   write_pos,
	output logic [sfrb_pkg::POS_OUT_W-1:0]   read_pos,
	output logic [sfrb_pkg::CRC_W-1:0]       snapshot_check,
	output logic                             link_up,
	output logic [sfrb_pkg::TOTAL_W-1:0]     stores_total,
	output logic [sfrb_pkg::TOTAL_W-1:0]     reads_total
);
	import sfrb_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	sfrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	sfrb_datapath #(
		.DEPTH        (DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.out_stall      (out_stall),
		.action         (action),
		.entry_kind     (entry_kind),
		.entry_word     (entry_word),
		.saved_count    (saved_count),
		.saved_head     (saved_head),
		.saved_tail     (saved_tail),
		.saved_check    (saved_check),
		.out_valid      (out_valid),
		.status         (status),
		.out_kind       (out_kind),
		.out_word       (out_word),
		.fill_count     (fill_count),
		.write_pos      (write_pos),
		.read_pos       (read_pos),
		.snapshot_check (snapshot_check),
		.link_up        (link_up),
		.stores_total   (stores_total),
		.reads_total    (reads_total)
	);

endmodule
